### sv/stc_pkg.sv
package stc_pkg;

    localparam int SAMPLE_DEPTH = 16;
    localparam int CNT_W        = $clog2(SAMPLE_DEPTH + 1);
    localparam int WALK_W       = $clog2(SAMPLE_DEPTH);

    localparam int TIME_W  = 32;
    localparam int SPEED_W = 15;
    localparam int TOL_W   = 16;
    localparam int BRT_W   = 7;
    localparam int IVL_W   = 16;
    localparam int WIN_W   = 16;
    localparam int LEVEL_W = 8;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(200);
    localparam logic [BRT_W-1:0] BRT_RESET = BRT_W'(100);
    localparam logic [IVL_W-1:0] IVL_RESET = IVL_W'(500);
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(3000);

    // x / 100 as (x * RECIP_100) >> RECIP_SHIFT, exact for x below 2^15
    localparam int RECIP_100   = 5243;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;

    typedef enum logic [1:0] {
        TREND_STABLE = 2'd0,
        TREND_ACCEL  = 2'd1,
        TREND_DECEL  = 2'd2
    } trend_t;

    typedef enum logic [2:0] {
        REG_ENABLE     = 3'd0,
        REG_TOLERANCE  = 3'd1,
        REG_BRIGHTNESS = 3'd2,
        REG_INTERVAL   = 3'd3,
        REG_WINDOW     = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0]  stamp;
        logic [SPEED_W-1:0] speed;
    } sample_t;

    // search token handed down the row of samples, newest first
    typedef struct packed {
        logic               found;
        logic [SPEED_W-1:0] base;
    } probe_t;

endpackage

### sv/stc_cell.sv
module stc_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift_en,
    input  stc_pkg::sample_t             sample_in,
    output stc_pkg::sample_t             sample_out,
    input  logic                         valid,
    input  logic [stc_pkg::TIME_W-1:0]   now,
    input  logic [stc_pkg::WIN_W-1:0]    window,
    input  stc_pkg::probe_t              probe_in,
    output stc_pkg::probe_t              probe_out
);
    import stc_pkg::*;

    sample_t            sample_reg;
    probe_t             probe_reg;
    probe_t             probe_next;
    logic [TIME_W-1:0]  age;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            sample_reg <= sample_in;
        end
    end

    assign age = now - sample_reg.stamp;

    always_comb
    begin
        probe_next = probe_in;
        if (!probe_in.found && valid && (age >= TIME_W'(window)))
        begin
            probe_next.found = 1'b1;
            probe_next.base  = sample_reg.speed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    assign sample_out = sample_reg;
    assign probe_out  = probe_reg;

endmodule

### sv/speed_trend_classifier.sv
// Speed trend indicator. Each accepted reading (speed, invalid flag, ms time) yields one
// result: trend and, when the visible LED state changes, an RGB level scaled by
// brightness. Readings are kept newest first in a row of SAMPLE_DEPTH cells; the
// baseline search runs as a token passed one cell per clock. After the transfer the item
// walks the row in S_WALK and then waits in S_DONE until the output register is free;
// there the result is registered and the block returns to S_IDLE to take the next reading,
// so it handles one item at a time. A disabled item skips the search: it goes straight
// to S_DONE, and its result is registered the same way. A finished result sits in
// the output register while the next reading is taken in; an item whose result is ready
// waits until the previous result has been taken.
module speed_trend_classifier (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [stc_pkg::ADDR_W-1:0]   paddr,
    input  logic [stc_pkg::DATA_W-1:0]   pwdata,
    output logic [stc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    // readings
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [15:0]           speed,
    input  logic                         speed_invalid,
    input  logic [31:0]                  now_ms,
    // results
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   trend,
    output logic                         led_write,
    output logic [7:0]                   red,
    output logic [7:0]                   green,
    output logic [7:0]                   blue
);
    import stc_pkg::*;

    // configuration registers
    logic               enable_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [BRT_W-1:0]   brt_reg;
    logic [IVL_W-1:0]   ivl_reg;
    logic [WIN_W-1:0]   win_reg;
    reg_idx_t           reg_idx;
    logic               cfg_wr;

    // control
    state_t             state_reg, state_next;
    logic [WALK_W-1:0]  walk_cnt_reg, walk_cnt_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TIME_W-1:0]  last_time_reg, last_time_next;
    trend_t             trend_state_reg, trend_state_next;
    logic               led_lit_reg, led_lit_next;
    logic [BRT_W-1:0]   shown_brt_reg, shown_brt_next;

    // item payload held through the walk
    logic [SPEED_W-1:0] spd_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [SPEED_W-1:0] spd_in;

    // output register
    logic               out_valid_reg, out_valid_next;
    trend_t             out_trend_reg, out_trend_next;
    logic               out_wr_reg, out_wr_next;
    logic [LEVEL_W-1:0] out_r_reg, out_r_next;
    logic [LEVEL_W-1:0] out_g_reg, out_g_next;
    logic [LEVEL_W-1:0] out_b_reg, out_b_next;

    logic               in_xfer;
    logic               store;
    logic               out_free;

    sample_t            sample_chain [SAMPLE_DEPTH+1];
    probe_t             probe_chain  [SAMPLE_DEPTH+1];

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            tol_reg    <= TOL_RESET;
            brt_reg    <= BRT_RESET;
            ivl_reg    <= IVL_RESET;
            win_reg    <= WIN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_ENABLE:     enable_reg <= pwdata[0];
                REG_TOLERANCE:  tol_reg    <= pwdata[TOL_W-1:0];
                REG_BRIGHTNESS: brt_reg    <= pwdata[BRT_W-1:0];
                REG_INTERVAL:   ivl_reg    <= pwdata[IVL_W-1:0];
                REG_WINDOW:     win_reg    <= pwdata[WIN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ENABLE:     prdata = DATA_W'(enable_reg);
            REG_TOLERANCE:  prdata = DATA_W'(tol_reg);
            REG_BRIGHTNESS: prdata = DATA_W'(brt_reg);
            REG_INTERVAL:   prdata = DATA_W'(ivl_reg);
            REG_WINDOW:     prdata = DATA_W'(win_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- input side ----------------
    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign spd_in   = (speed_invalid || speed[15]) ? '0 : speed[SPEED_W-1:0];
    assign store    = in_xfer && enable_reg &&
                      ((count_reg == '0) || ((now_ms - last_time_reg) >= TIME_W'(ivl_reg)));

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            spd_reg <= spd_in;
            now_reg <= now_ms;
        end
    end

    // ---------------- sample row ----------------
    assign sample_chain[0] = '{stamp: now_ms, speed: spd_in};
    assign probe_chain[0]  = '0;

    for (genvar k = 0; k < SAMPLE_DEPTH; k++)
    begin : g_cell
        stc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (store),
            .sample_in  (sample_chain[k]),
            .sample_out (sample_chain[k+1]),
            .valid      (CNT_W'(k) < count_reg),
            .now        (now_reg),
            .window     (win_reg),
            .probe_in   (probe_chain[k]),
            .probe_out  (probe_chain[k+1])
        );
    end

    // ---------------- classify and LED ----------------
    logic [SPEED_W+1:0]       spd_ext, base_ext, tol_ext;
    logic                     base_ok;
    trend_t                   trend_calc;
    logic [SPEED_W-1:0]       brt_x255;
    logic [SPEED_W+RECIP_W-1:0] level_prod;
    logic [8:0]               level_raw;
    logic [LEVEL_W-1:0]       level;
    logic                     led_change;

    assign spd_ext  = (SPEED_W+2)'(spd_reg);
    assign base_ext = (SPEED_W+2)'(probe_chain[SAMPLE_DEPTH].base);
    assign tol_ext  = (SPEED_W+2)'(tol_reg);
    assign base_ok  = probe_chain[SAMPLE_DEPTH].found && (count_reg >= CNT_W'(2));

    always_comb
    begin
        trend_calc = TREND_STABLE;
        if (base_ok)
        begin
            priority if (spd_ext > base_ext + tol_ext)
                trend_calc = TREND_ACCEL;
            else if (spd_ext + tol_ext < base_ext)
                trend_calc = TREND_DECEL;
            else
                trend_calc = TREND_STABLE;
        end
    end

    assign brt_x255   = {brt_reg, 8'b0} - SPEED_W'(brt_reg);
    assign level_prod = (SPEED_W+RECIP_W)'(brt_x255) * (SPEED_W+RECIP_W)'(RECIP_100);
    assign level_raw  = level_prod[RECIP_SHIFT+8:RECIP_SHIFT];
    assign level      = level_raw[8] ? 8'hFF : level_raw[7:0];

    assign led_change = !led_lit_reg || (trend_calc != trend_state_reg) ||
                        (shown_brt_reg != brt_reg);

    assign out_free = !out_valid_reg || out_ready;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next       = state_reg;
        walk_cnt_next    = walk_cnt_reg;
        count_next       = count_reg;
        last_time_next   = last_time_reg;
        trend_state_next = trend_state_reg;
        led_lit_next     = led_lit_reg;
        shown_brt_next   = shown_brt_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_trend_next   = out_trend_reg;
        out_wr_next      = out_wr_reg;
        out_r_next       = out_r_reg;
        out_g_next       = out_g_reg;
        out_b_next       = out_b_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    walk_cnt_next = '0;
                    state_next    = enable_reg ? S_WALK : S_DONE;
                    if (store)
                    begin
                        last_time_next = now_ms;
                        if (count_reg < CNT_W'(SAMPLE_DEPTH))
                            count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            S_WALK:
            begin
                walk_cnt_next = walk_cnt_reg + WALK_W'(1);
                if (walk_cnt_reg == WALK_W'(SAMPLE_DEPTH - 1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_r_next     = '0;
                    out_g_next     = '0;
                    out_b_next     = '0;
                    if (!enable_reg)
                    begin
                        out_trend_next   = TREND_STABLE;
                        out_wr_next      = led_lit_reg;
                        led_lit_next     = 1'b0;
                        shown_brt_next   = '0;
                        count_next       = '0;
                        last_time_next   = '0;
                        trend_state_next = TREND_STABLE;
                    end
                    else
                    begin
                        out_wr_next    = led_change;
                        out_trend_next = trend_state_reg;
                        if (led_change)
                        begin
                            trend_state_next = trend_calc;
                            out_trend_next   = trend_calc;
                            led_lit_next     = 1'b1;
                            shown_brt_next   = brt_reg;
                            unique case (trend_calc)
                                TREND_ACCEL:
                                begin
                                    out_r_next = level;
                                    out_b_next = level;
                                end
                                TREND_DECEL: out_r_next = level;
                                default:     out_g_next = level;
                            endcase
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            walk_cnt_reg    <= '0;
            count_reg       <= '0;
            last_time_reg   <= '0;
            trend_state_reg <= TREND_STABLE;
            led_lit_reg     <= 1'b0;
            shown_brt_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            walk_cnt_reg    <= walk_cnt_next;
            count_reg       <= count_next;
            last_time_reg   <= last_time_next;
            trend_state_reg <= trend_state_next;
            led_lit_reg     <= led_lit_next;
            shown_brt_reg   <= shown_brt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_trend_reg <= out_trend_next;
        out_wr_reg    <= out_wr_next;
        out_r_reg     <= out_r_next;
        out_g_reg     <= out_g_next;
        out_b_reg     <= out_b_next;
    end

    assign out_valid = out_valid_reg;
    assign trend     = out_trend_reg;
    assign led_write = out_wr_reg;
    assign red       = out_r_reg;
    assign green     = out_g_reg;
    assign blue      = out_b_reg;

    // ---------------- checks ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SAMPLE_DEPTH))
        else $error("sample count beyond depth");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("second reading taken while one is in flight");

    a_no_write_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !led_write) |-> (red == '0 && green == '0 && blue == '0))
        else $error("color without LED write");

    a_stable_green: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && trend == TREND_STABLE) |-> (red == '0 && blue == '0))
        else $error("stable trend shows red or blue");

    a_walk_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && walk_cnt_reg == WALK_W'(SAMPLE_DEPTH - 1)) |=>
        (state_reg == S_DONE))
        else $error("search walk did not end on time");

endmodule

### tb/tb_top.sv
module tb_top;
    import stc_pkg::*;

    typedef struct packed {
        trend_t             trend;
        logic               led_write;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } led_result_t;

    typedef struct {
        bit                 is_cfg;
        int unsigned        reg_sel;
        logic [DATA_W-1:0]  wdata;
        logic [15:0]        raw;
        logic               inv;
        logic [TIME_W-1:0]  stamp;
        bit                 typed;
        led_result_t        want;
    } script_row_t;

    localparam led_result_t RES_QUIET      = '{TREND_STABLE, 1'b0, 8'd0, 8'd0, 8'd0};
    localparam led_result_t RES_OFF        = '{TREND_STABLE, 1'b1, 8'd0, 8'd0, 8'd0};
    localparam led_result_t RES_GREEN_FULL = '{TREND_STABLE, 1'b1, 8'd0, 8'd255, 8'd0};

    localparam bit          ROW_PREDICTED = 1'b0;
    localparam bit          ROW_TYPED     = 1'b1;
    localparam int unsigned REG_UNUSED    = 5;
    localparam int          HOLD_AT       = 420;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          MAX_REPORTS   = 50;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [ADDR_W-1:0]   paddr         = '0;
    logic [DATA_W-1:0]   pwdata        = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid      = 1'b0;
    logic                in_ready;
    logic signed [15:0]  speed         = '0;
    logic                speed_invalid = 1'b0;
    logic [31:0]         now_ms        = '0;
    logic                out_valid;
    logic                out_ready     = 1'b0;
    logic [1:0]          trend;
    logic                led_write;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;

    speed_trend_classifier u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .speed         (speed),
        .speed_invalid (speed_invalid),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .trend         (trend),
        .led_write     (led_write),
        .red           (red),
        .green         (green),
        .blue          (blue)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the block: sample ring, LED state and register copies
    logic [TIME_W-1:0]  hist_time [SAMPLE_DEPTH];
    logic [SPEED_W-1:0] hist_speed [SAMPLE_DEPTH];
    int unsigned        hist_wr;
    int unsigned        hist_cnt;
    logic [TIME_W-1:0]  last_stored;
    trend_t             shown_trend;
    bit                 led_on;
    logic [BRT_W-1:0]   lit_brightness;

    logic               cfg_enable;
    logic [TOL_W-1:0]   cfg_tol;
    logic [BRT_W-1:0]   cfg_bright;
    logic [IVL_W-1:0]   cfg_interval;
    logic [WIN_W-1:0]   cfg_window;

    led_result_t        pending_led [$];
    script_row_t        script [$];
    int                 leds_checked = 0;
    int                 mismatches = 0;
    bit                 no_gaps = 1'b0;

    function automatic void clear_shadow();
        for (int i = 0; i < SAMPLE_DEPTH; i++)
        begin
            hist_time[i]  = '0;
            hist_speed[i] = '0;
        end
        hist_wr        = 0;
        hist_cnt       = 0;
        last_stored    = '0;
        shown_trend    = TREND_STABLE;
        led_on         = 1'b0;
        lit_brightness = '0;
        cfg_enable     = 1'b0;
        cfg_tol        = TOL_RESET;
        cfg_bright     = BRT_RESET;
        cfg_interval   = IVL_RESET;
        cfg_window     = WIN_RESET;
    endfunction

    function automatic void apply_setting(int unsigned idx, logic [DATA_W-1:0] value);
        case (idx)
            REG_ENABLE:     cfg_enable   = value[0];
            REG_TOLERANCE:  cfg_tol      = value[TOL_W-1:0];
            REG_BRIGHTNESS: cfg_bright   = value[BRT_W-1:0];
            REG_INTERVAL:   cfg_interval = value[IVL_W-1:0];
            REG_WINDOW:     cfg_window   = value[WIN_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic led_result_t classify_reading(logic [15:0] raw, logic inv,
                                                     logic [TIME_W-1:0] now);
        led_result_t       res;
        int unsigned       spd;
        int unsigned       base;
        int unsigned       level;
        int unsigned       slot;
        logic [TIME_W-1:0] age;
        bit                found;
        trend_t            next;

        res   = RES_QUIET;
        base  = 0;
        found = 1'b0;
        next  = TREND_STABLE;

        if (!cfg_enable)
        begin
            if (led_on)
            begin
                res.led_write  = 1'b1;
                led_on         = 1'b0;
                lit_brightness = '0;
            end
            hist_wr     = 0;
            hist_cnt    = 0;
            last_stored = '0;
            shown_trend = TREND_STABLE;
            return res;
        end

        spd = (inv || raw[15]) ? 0 : raw[14:0];

        age = now - last_stored;
        if (hist_cnt == 0 || age >= cfg_interval)
        begin
            hist_time[hist_wr]  = now;
            hist_speed[hist_wr] = spd[SPEED_W-1:0];
            hist_wr = (hist_wr + 1) % SAMPLE_DEPTH;
            if (hist_cnt < SAMPLE_DEPTH)
                hist_cnt++;
            last_stored = now;
        end

        // newest first; baseline is the first sample old enough
        if (hist_cnt >= 2)
        begin
            for (int unsigned k = 0; k < hist_cnt && !found; k++)
            begin
                slot = (hist_wr + SAMPLE_DEPTH - 1 - k) % SAMPLE_DEPTH;
                age  = now - hist_time[slot];
                if (age >= cfg_window)
                begin
                    found = 1'b1;
                    base  = hist_speed[slot];
                end
            end
        end

        if (found)
        begin
            if (spd > base + cfg_tol)
                next = TREND_ACCEL;
            else if (spd + cfg_tol < base)
                next = TREND_DECEL;
        end

        if (!led_on || next != shown_trend || lit_brightness != cfg_bright)
        begin
            level = cfg_bright * 255 / 100;
            if (level > 255)
                level = 255;
            res.led_write = 1'b1;
            case (next)
                TREND_ACCEL:
                begin
                    res.red  = level[7:0];
                    res.blue = level[7:0];
                end
                TREND_DECEL: res.red   = level[7:0];
                default:     res.green = level[7:0];
            endcase
            shown_trend    = next;
            led_on         = 1'b1;
            lit_brightness = cfg_bright;
        end

        res.trend = shown_trend;
        return res;
    endfunction

    function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    function automatic script_row_t cfg_row(int unsigned idx, logic [DATA_W-1:0] value);
        script_row_t r;
        r.is_cfg  = 1'b1;
        r.reg_sel = idx;
        r.wdata   = value;
        r.raw     = '0;
        r.inv     = 1'b0;
        r.stamp   = '0;
        r.typed   = ROW_PREDICTED;
        r.want    = RES_QUIET;
        return r;
    endfunction

    function automatic script_row_t item_row(logic [15:0] raw, logic inv,
                                             logic [TIME_W-1:0] stamp, bit typed,
                                             led_result_t want);
        script_row_t r;
        r.is_cfg  = 1'b0;
        r.reg_sel = 0;
        r.wdata   = '0;
        r.raw     = raw;
        r.inv     = inv;
        r.stamp   = stamp;
        r.typed   = typed;
        r.want    = want;
        return r;
    endfunction

    // random bits above the register width, which the block must drop
    function automatic logic [DATA_W-1:0] with_junk(logic [DATA_W-1:0] value, int w);
        if ($urandom_range(0, 3) == 0)
            return value | ($urandom << w);
        return value;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_reading(logic [15:0] raw, logic inv, logic [TIME_W-1:0] stamp,
                                bit typed, led_result_t want);
        int          gap;
        led_result_t pred;

        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        speed         <= raw;
        speed_invalid <= inv;
        now_ms        <= stamp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = classify_reading(raw, inv, stamp);
        pending_led.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_led.size() != 0)
            @(negedge clk);
        repeat (SAMPLE_DEPTH + 2) @(negedge clk);
    endtask

    // APB write, then, for a defined register, read back on the same select (back-to-back transfer)
    task automatic program_register(int unsigned idx, logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] readback;
        logic [DATA_W-1:0] held;

        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        apply_setting(idx, value);
        if (idx > REG_WINDOW)
        begin
            psel    <= 1'b0;
            penable <= 1'b0;
        end
        else
        begin
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            readback = prdata;
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            case (idx)
                REG_ENABLE:     held = DATA_W'(cfg_enable);
                REG_TOLERANCE:  held = DATA_W'(cfg_tol);
                REG_BRIGHTNESS: held = DATA_W'(cfg_bright);
                REG_INTERVAL:   held = DATA_W'(cfg_interval);
                default:        held = DATA_W'(cfg_window);
            endcase
            compare_field("register readback", held, readback);
        end
    endtask

    // result side: random stall once a result shows, one long hold-off
    initial
    begin : drain
        int          stall;
        led_result_t want;

        @(posedge rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 4);
            if (leds_checked == HOLD_AT)
                stall = HOLD_CYCLES;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                while (!out_valid)
                    @(negedge clk);
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (pending_led.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing expected: trend=%0d led_write=%0d",
                             $time, trend, led_write);
            end
            else
            begin
                want = pending_led.pop_front();
                compare_field("trend", want.trend, trend);
                compare_field("led_write", want.led_write, led_write);
                compare_field("red", want.red, red);
                compare_field("green", want.green, green);
                compare_field("blue", want.blue, blue);
            end
            leds_checked++;
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        logic [15:0]       raw;
        logic              inv;
        logic [TIME_W-1:0] t;
        int                v;
        int                swing;
        int                step_max;
        int unsigned       en;
        int unsigned       tol;
        int unsigned       bright;
        int unsigned       ivl;
        int unsigned       win;

        clear_shadow();

        // reset settings: tolerance 200, brightness 100, interval 500, window 3000
        script.push_back(item_row(16'd100, 1'b0, 32'd0, ROW_TYPED, RES_QUIET));
        script.push_back(cfg_row(REG_ENABLE, 32'd1));
        // first sample lights the LED green
        script.push_back(item_row(16'd1000, 1'b0, 32'd1000, ROW_TYPED, RES_GREEN_FULL));
        // inside the interval: not stored, nothing visible changes
        script.push_back(item_row(16'd1000, 1'b0, 32'd1100, ROW_TYPED, RES_QUIET));
        // two samples, none old enough
        script.push_back(item_row(16'h7FFF, 1'b0, 32'd1500, ROW_TYPED, RES_QUIET));
        script.push_back(item_row(16'h7FFF, 1'b0, 32'd4000, ROW_PREDICTED, RES_QUIET));
        // most negative reading clamps to zero
        script.push_back(item_row(16'h8000, 1'b0, 32'd4100, ROW_PREDICTED, RES_QUIET));
        script.push_back(item_row(16'd5000, 1'b1, 32'd4200, ROW_PREDICTED, RES_QUIET));
        script.push_back(cfg_row(REG_BRIGHTNESS, 32'd0));
        script.push_back(item_row(16'd0, 1'b0, 32'd4300, ROW_PREDICTED, RES_QUIET));
        // above 100 percent saturates
        script.push_back(cfg_row(REG_BRIGHTNESS, 32'd127));
        script.push_back(item_row(16'd0, 1'b0, 32'd4400, ROW_PREDICTED, RES_QUIET));
        script.push_back(cfg_row(REG_TOLERANCE, 32'd65535));
        script.push_back(item_row(16'h7FFF, 1'b0, 32'd4500, ROW_PREDICTED, RES_QUIET));
        script.push_back(cfg_row(REG_TOLERANCE, 32'd0));
        script.push_back(cfg_row(REG_WINDOW, 32'd0));
        script.push_back(item_row(16'd700, 1'b0, 32'd4600, ROW_PREDICTED, RES_QUIET));
        // zero interval stores every reading; equal to baseline is stable
        script.push_back(cfg_row(REG_INTERVAL, 32'd0));
        script.push_back(item_row(16'd700, 1'b0, 32'd4600, ROW_PREDICTED, RES_QUIET));
        script.push_back(cfg_row(REG_INTERVAL, 32'd65535));
        script.push_back(cfg_row(REG_WINDOW, 32'd65535));
        // time wraps through zero
        script.push_back(item_row(16'd701, 1'b0, 32'hFFFF_FFF0, ROW_PREDICTED, RES_QUIET));
        script.push_back(item_row(16'd699, 1'b0, 32'h0000_0020, ROW_PREDICTED, RES_QUIET));
        script.push_back(item_row(16'hFFFF, 1'b1, 32'h0000_0021, ROW_PREDICTED, RES_QUIET));
        script.push_back(cfg_row(REG_UNUSED, 32'hFFFF_FFFF));
        // disable while lit: LED written off once, then silent
        script.push_back(cfg_row(REG_ENABLE, 32'd0));
        script.push_back(item_row(16'd1234, 1'b0, 32'd100, ROW_TYPED, RES_OFF));
        script.push_back(item_row(16'd1234, 1'b0, 32'd200, ROW_TYPED, RES_QUIET));

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                settle();
                program_register(script[i].reg_sel, script[i].wdata);
            end
            else
            begin
                send_reading(script[i].raw, script[i].inv, script[i].stamp,
                             script[i].typed, script[i].want);
            end
        end

        for (int phase = 0; phase < 12; phase++)
        begin
            settle();
            no_gaps = (phase % 4 == 2);

            en = (phase == 5 || phase == 9) ? 0 : 1;
            case ($urandom_range(0, 5))
                0:       tol = 0;
                1:       tol = 65535;
                2, 3:    tol = $urandom_range(0, 300);
                default: tol = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 4))
                0:       bright = 0;
                1:       bright = 100;
                2:       bright = 127;
                default: bright = $urandom_range(0, 127);
            endcase
            case ($urandom_range(0, 5))
                0:       ivl = 0;
                1:       ivl = 65535;
                default: ivl = $urandom_range(0, 40);
            endcase
            case ($urandom_range(0, 5))
                0:       win = 0;
                1:       win = 65535;
                default: win = $urandom_range(0, 300);
            endcase

            program_register(REG_ENABLE, with_junk(en, 1));
            program_register(REG_TOLERANCE, with_junk(tol, TOL_W));
            program_register(REG_BRIGHTNESS, with_junk(bright, BRT_W));
            program_register(REG_INTERVAL, with_junk(ivl, IVL_W));
            program_register(REG_WINDOW, with_junk(win, WIN_W));
            if (phase == 3)
                program_register(REG_UNUSED, $urandom);

            t        = (phase % 3 == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2000) : $urandom;
            v        = $urandom_range(0, 32767);
            step_max = cfg_interval + cfg_window / 4 + 5;
            swing    = cfg_tol * 2 + 50;
            if (swing > 4000)
                swing = 4000;

            for (int n = 0; n < 62; n++)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    // steady time and a speed walk around the dead band
                    t = t + $urandom_range(0, step_max);
                    v = v + $urandom_range(0, 2 * swing) - swing;
                    if (v < 0)
                        v = 0;
                    if (v > 32767)
                        v = 32767;
                    raw = v[15:0];
                    inv = ($urandom_range(0, 19) == 0);
                    if ($urandom_range(0, 19) == 0)
                        raw = 16'(32'd65536 - $urandom_range(1, 32768));
                end
                else
                begin
                    raw = $urandom;
                    inv = $urandom_range(0, 1);
                    case ($urandom_range(0, 2))
                        0:       t = $urandom;
                        1:       t = t - $urandom_range(0, 1000);
                        default: ;
                    endcase
                end
                send_reading(raw, inv, t, ROW_PREDICTED, RES_QUIET);
            end
        end

        in_valid <= 1'b0;
        while (pending_led.size() != 0)
            @(negedge clk);
        repeat (2 * (SAMPLE_DEPTH + 2)) @(negedge clk);

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
